[src/sdsp_pkg.sv]
package sdsp_pkg;

   localparam int RING_SEGMENTS = 512;
   localparam int SEGMENT_BYTES = 48;

   localparam int SLOT_W     = $clog2(RING_SEGMENTS);
   localparam int LEN_W      = $clog2(SEGMENT_BYTES + 1);
   localparam int COUNT_W    = $clog2(RING_SEGMENTS + 1);
   localparam int BYTE_DEPTH = RING_SEGMENTS * SEGMENT_BYTES;
   localparam int BADDR_W    = $clog2(BYTE_DEPTH);

   // Request codes.
   localparam logic [2:0] REQ_PUSH_DATA  = 3'd0;
   localparam logic [2:0] REQ_PUSH_LEVEL = 3'd1;
   localparam logic [2:0] REQ_TICK       = 3'd2;
   localparam logic [2:0] REQ_XFER_ERROR = 3'd3;
   localparam logic [2:0] REQ_ABORT      = 3'd4;

   // Status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_RING_FULL = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

   typedef struct packed {
      logic [2:0] req_type;
      logic       cs_level;
      logic       dc_level;
      logic [7:0] data_byte;
      logic       seg_end;
   } sdsp_req_beat_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               byte_valid;
      logic [7:0]         byte_out;
      logic               cs_out;
      logic               dc_out;
      logic [COUNT_W-1:0] queued;
      logic               busy_res;
   } sdsp_rsp_beat_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } sdsp_cmd_type;

   // One entry of the segment descriptor memory.
   typedef struct packed {
      logic             cs;
      logic             dc;
      logic [LEN_W-1:0] len;
   } sdsp_seg_type;

endpackage

[src/spi_display_segment_player_core.sv]
// Segment player for a serial display link. Each request beat is taken while
// the controller is idle and executed afterwards, against the segment descriptor
// and the byte read into registers from their memories at the head of the ring,
// so a new beat is not accepted until the previous one has executed.
// Execution waits while the previous result beat has not been taken. No
// clearing pass follows reset; descriptors are written only on a commit.
module spi_display_segment_player_core
   import sdsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sdsp_req_beat_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sdsp_rsp_beat_type rsp_data
);

   sdsp_cmd_type cmd;

   sdsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sdsp_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

[src/sdsp_ctrl.sv]
module sdsp_ctrl
   import sdsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sdsp_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // The result register is free when empty or when its beat leaves this cycle.
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.execute = (state_ff == ST_EXEC) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_EXEC;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_EXEC: begin
               if (out_free) begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               req_ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready_ff |-> (state_ff == ST_IDLE))
      else $error("request ready outside idle");
   a_exec_loads_result: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_valid_ff)
      else $error("executed request left no result");
   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_EXEC) && !req_ready_ff)
      else $error("captured request not executed");
`endif

endmodule

[src/sdsp_datapath.sv]
module sdsp_datapath
   import sdsp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  sdsp_cmd_type      cmd,
   input  sdsp_req_beat_type req_data,
   output sdsp_rsp_beat_type rsp_data
);

   localparam logic [SLOT_W-1:0]  LAST_SLOT = SLOT_W'(RING_SEGMENTS - 1);
   localparam logic [BADDR_W-1:0] SEG_STEP  = BADDR_W'(SEGMENT_BYTES);
   localparam logic [COUNT_W-1:0] RING_FULL = COUNT_W'(RING_SEGMENTS);
   localparam logic [LEN_W-1:0]   SEG_MAX   = LEN_W'(SEGMENT_BYTES);

   sdsp_seg_type seg_mem [RING_SEGMENTS];
   logic [7:0]   byte_mem [BYTE_DEPTH];

   sdsp_req_beat_type req_ff;
   sdsp_rsp_beat_type rsp_ff, rsp_in;

   logic [SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]  read_slot_ff, read_slot_in;
   logic [BADDR_W-1:0] wr_base_ff, wr_base_in;
   logic [BADDR_W-1:0] rd_base_ff, rd_base_in;
   logic [COUNT_W-1:0] seg_count_ff, seg_count_in;
   logic [LEN_W-1:0]   build_len_ff, build_len_in;
   logic [LEN_W-1:0]   play_offset_ff, play_offset_in;
   logic               cs_pin_ff, cs_pin_in;
   logic               dc_pin_ff, dc_pin_in;

   sdsp_seg_type       meta_rd_ff;
   logic [7:0]         byte_rd_ff;
   logic [BADDR_W-1:0] byte_wr_addr;
   logic [BADDR_W-1:0] byte_rd_addr;
   logic               byte_we;
   logic               seg_we;
   sdsp_seg_type       seg_wr;
   logic [LEN_W-1:0]   len_plus;
   logic [LEN_W-1:0]   off_plus;
   logic               commit;
   logic               drop;
   logic               ring_full;

   assign byte_wr_addr = wr_base_ff + BADDR_W'(build_len_ff);
   assign byte_rd_addr = rd_base_ff + BADDR_W'(play_offset_ff);
   assign len_plus     = build_len_ff + LEN_W'(1);
   assign off_plus     = play_offset_ff + LEN_W'(1);
   assign ring_full    = seg_count_ff >= RING_FULL;

   always_comb begin
      write_slot_in  = write_slot_ff;
      read_slot_in   = read_slot_ff;
      wr_base_in     = wr_base_ff;
      rd_base_in     = rd_base_ff;
      seg_count_in   = seg_count_ff;
      build_len_in   = build_len_ff;
      play_offset_in = play_offset_ff;
      cs_pin_in      = cs_pin_ff;
      dc_pin_in      = dc_pin_ff;
      byte_we        = 1'b0;
      seg_we         = 1'b0;
      seg_wr         = '{cs: req_ff.cs_level, dc: req_ff.dc_level, len: '0};
      commit         = 1'b0;
      drop           = 1'b0;
      rsp_in         = '0;
      rsp_in.status  = STATUS_OK;

      unique case (req_ff.req_type)
         REQ_PUSH_DATA: begin
            if (ring_full) begin
               rsp_in.status = STATUS_RING_FULL;
            end else if (build_len_ff >= SEG_MAX) begin
               rsp_in.status = STATUS_TOO_LONG;
            end else begin
               byte_we      = 1'b1;
               build_len_in = len_plus;
               if (req_ff.seg_end) begin
                  seg_wr.len = len_plus;
                  commit     = 1'b1;
               end
            end
         end
         REQ_PUSH_LEVEL: begin
            if (ring_full) begin
               rsp_in.status = STATUS_RING_FULL;
            end else begin
               commit = 1'b1;
            end
         end
         REQ_TICK: begin
            if (seg_count_ff != '0) begin
               cs_pin_in = meta_rd_ff.cs;
               dc_pin_in = meta_rd_ff.dc;
               if (meta_rd_ff.len == '0 || play_offset_ff >= meta_rd_ff.len ||
                   play_offset_ff >= SEG_MAX) begin
                  drop = 1'b1;
               end else begin
                  rsp_in.byte_valid = 1'b1;
                  rsp_in.byte_out   = byte_rd_ff;
                  play_offset_in    = off_plus;
                  if (off_plus >= meta_rd_ff.len) begin
                     drop = 1'b1;
                  end
               end
            end
         end
         REQ_XFER_ERROR: begin
            if (seg_count_ff != '0) begin
               drop = 1'b1;
            end
         end
         REQ_ABORT: begin
         end
         default: begin
         end
      endcase

      // Commit and drop never happen on the same request.
      if (commit) begin
         seg_we        = 1'b1;
         write_slot_in = (write_slot_ff == LAST_SLOT) ? '0 : write_slot_ff + SLOT_W'(1);
         wr_base_in    = (write_slot_ff == LAST_SLOT) ? '0 : wr_base_ff + SEG_STEP;
         seg_count_in  = seg_count_ff + COUNT_W'(1);
         build_len_in  = '0;
      end
      if (drop) begin
         read_slot_in   = (read_slot_ff == LAST_SLOT) ? '0 : read_slot_ff + SLOT_W'(1);
         rd_base_in     = (read_slot_ff == LAST_SLOT) ? '0 : rd_base_ff + SEG_STEP;
         seg_count_in   = seg_count_ff - COUNT_W'(1);
         play_offset_in = '0;
      end
      if (req_ff.req_type == REQ_ABORT) begin
         write_slot_in  = '0;
         read_slot_in   = '0;
         wr_base_in     = '0;
         rd_base_in     = '0;
         seg_count_in   = '0;
         build_len_in   = '0;
         play_offset_in = '0;
         cs_pin_in      = 1'b1;
      end

      rsp_in.cs_out   = cs_pin_in;
      rsp_in.dc_out   = dc_pin_in;
      rsp_in.queued   = seg_count_in;
      rsp_in.busy_res = seg_count_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff  <= '0;
         read_slot_ff   <= '0;
         wr_base_ff     <= '0;
         rd_base_ff     <= '0;
         seg_count_ff   <= '0;
         build_len_ff   <= '0;
         play_offset_ff <= '0;
         cs_pin_ff      <= 1'b1;
         dc_pin_ff      <= 1'b1;
      end else if (cmd.execute) begin
         write_slot_ff  <= write_slot_in;
         read_slot_ff   <= read_slot_in;
         wr_base_ff     <= wr_base_in;
         rd_base_ff     <= rd_base_in;
         seg_count_ff   <= seg_count_in;
         build_len_ff   <= build_len_in;
         play_offset_ff <= play_offset_in;
         cs_pin_ff      <= cs_pin_in;
         dc_pin_ff      <= dc_pin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   // The head descriptor and the head byte are read every cycle, so the read
   // data is ready by the time a captured tick executes.
   always_ff @(posedge clock) begin
      if (seg_we && cmd.execute) begin
         seg_mem[write_slot_ff] <= seg_wr;
      end
      meta_rd_ff <= seg_mem[read_slot_ff];
   end

   always_ff @(posedge clock) begin
      if (byte_we && cmd.execute) begin
         byte_mem[byte_wr_addr] <= req_ff.data_byte;
      end
      byte_rd_ff <= byte_mem[byte_rd_addr];
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      seg_count_ff <= RING_FULL)
      else $error("segment count above ring size");
   a_build_bound: assert property (@(posedge clock) disable iff (reset)
      build_len_ff <= SEG_MAX)
      else $error("segment build longer than allowed");
   a_empty_slots: assert property (@(posedge clock) disable iff (reset)
      (seg_count_ff == '0) |-> (write_slot_ff == read_slot_ff))
      else $error("empty ring with unequal slots");
   a_read_base: assert property (@(posedge clock) disable iff (reset)
      rd_base_ff == BADDR_W'(read_slot_ff * SEGMENT_BYTES))
      else $error("read base out of step with read slot");
   a_write_base: assert property (@(posedge clock) disable iff (reset)
      wr_base_ff == BADDR_W'(write_slot_ff * SEGMENT_BYTES))
      else $error("write base out of step with write slot");
`endif

endmodule

[test/tb.sv]
module tb;
   import sdsp_pkg::*;

   // Request codes that the block treats as no operation.
   localparam logic [2:0] REQ_SPARE_5 = 3'd5;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;

   localparam int QUIET_LIMIT = 2000;
   localparam int MAX_REPORTS = 200;

   typedef struct packed {
      sdsp_req_beat_type beat;
      logic              typed;
      sdsp_rsp_beat_type want;
   } directed_row_type;

   localparam sdsp_rsp_beat_type NO_RSP = '0;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   sdsp_req_beat_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   sdsp_rsp_beat_type rsp_data;

   spi_display_segment_player_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Shadow copy of the segment ring.
   logic             ring_cs    [RING_SEGMENTS];
   logic             ring_dc    [RING_SEGMENTS];
   logic [LEN_W-1:0] ring_len   [RING_SEGMENTS];
   logic [7:0]       ring_bytes [BYTE_DEPTH];
   int unsigned      tail_slot;
   int unsigned      head_slot;
   int unsigned      live_segments;
   int unsigned      build_fill;
   int unsigned      play_pos;
   logic             cs_pin;
   logic             dc_pin;

   sdsp_rsp_beat_type awaited_link_beats [$];
   directed_row_type  directed_rows [$];

   int mismatches    = 0;
   int beats_sent    = 0;
   int results_seen  = 0;
   int bytes_played  = 0;
   int full_rejects  = 0;
   int long_rejects  = 0;
   int quiet_cycles  = 0;
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;

   function automatic void seg_commit(input logic cs, input logic dc, input int unsigned len);
      ring_cs[tail_slot]  = cs;
      ring_dc[tail_slot]  = dc;
      ring_len[tail_slot] = LEN_W'(len);
      tail_slot = (tail_slot + 1 == RING_SEGMENTS) ? 0 : tail_slot + 1;
      live_segments++;
      build_fill = 0;
   endfunction

   function automatic void seg_retire();
      head_slot = (head_slot + 1 == RING_SEGMENTS) ? 0 : head_slot + 1;
      live_segments--;
      play_pos = 0;
   endfunction

   function automatic sdsp_rsp_beat_type link_step_predict(input sdsp_req_beat_type rq);
      sdsp_rsp_beat_type res;
      int unsigned       seg_len;
      res = '0;
      res.status = STATUS_OK;
      case (rq.req_type)
         REQ_PUSH_DATA: begin
            if (live_segments >= RING_SEGMENTS) begin
               res.status = STATUS_RING_FULL;
            end else if (build_fill >= SEGMENT_BYTES) begin
               res.status = STATUS_TOO_LONG;
            end else begin
               ring_bytes[tail_slot * SEGMENT_BYTES + build_fill] = rq.data_byte;
               build_fill++;
               if (rq.seg_end) seg_commit(rq.cs_level, rq.dc_level, build_fill);
            end
         end
         REQ_PUSH_LEVEL: begin
            // Any bytes of a partial build are thrown away when the level push commits.
            if (live_segments >= RING_SEGMENTS) res.status = STATUS_RING_FULL;
            else seg_commit(rq.cs_level, rq.dc_level, 0);
         end
         REQ_TICK: begin
            if (live_segments != 0) begin
               seg_len = int'(ring_len[head_slot]);
               cs_pin  = ring_cs[head_slot];
               dc_pin  = ring_dc[head_slot];
               if (seg_len == 0 || play_pos >= seg_len) begin
                  seg_retire();
               end else begin
                  res.byte_valid = 1'b1;
                  res.byte_out   = ring_bytes[head_slot * SEGMENT_BYTES + play_pos];
                  play_pos++;
                  if (play_pos >= seg_len) seg_retire();
               end
            end
         end
         REQ_XFER_ERROR: begin
            if (live_segments != 0) seg_retire();
         end
         REQ_ABORT: begin
            live_segments = 0;
            tail_slot     = 0;
            head_slot     = 0;
            build_fill    = 0;
            play_pos      = 0;
            cs_pin        = 1'b1;
         end
         default: begin
         end
      endcase
      res.cs_out   = cs_pin;
      res.dc_out   = dc_pin;
      res.queued   = COUNT_W'(live_segments);
      res.busy_res = (live_segments != 0);
      return res;
   endfunction

   function automatic sdsp_req_beat_type mk_req(input logic [2:0] kind, input logic cs,
                                                input logic dc, input logic [7:0] data,
                                                input logic last);
      sdsp_req_beat_type rq;
      rq.req_type  = kind;
      rq.cs_level  = cs;
      rq.dc_level  = dc;
      rq.data_byte = data;
      rq.seg_end   = last;
      return rq;
   endfunction

   function automatic sdsp_req_beat_type rand_req(input logic [2:0] kind);
      return mk_req(kind, 1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
   endfunction

   function automatic sdsp_rsp_beat_type mk_rsp(input logic [1:0] st, input logic vld,
                                                input logic [7:0] data, input logic cs,
                                                input logic dc, input int q);
      sdsp_rsp_beat_type r;
      r.status     = st;
      r.byte_valid = vld;
      r.byte_out   = data;
      r.cs_out     = cs;
      r.dc_out     = dc;
      r.queued     = COUNT_W'(q);
      r.busy_res   = (q != 0);
      return r;
   endfunction

   task automatic compare_field(input string what, input logic [9:0] want,
                                input logic [9:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   // Holds the beat until it is taken, then books its expected result.
   task automatic send_beat(input sdsp_req_beat_type beat, input logic typed = 1'b0,
                            input sdsp_rsp_beat_type typed_want = '0);
      sdsp_rsp_beat_type predicted;
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = link_step_predict(beat);
      awaited_link_beats.push_back(typed ? typed_want : predicted);
      beats_sent++;
      if (sender_idles && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      while (awaited_link_beats.size() != 0) @(posedge clock);
   endtask

   // A level-only push for zero bytes, otherwise data pushes closed by seg_end.
   task automatic send_segment(input int n_bytes);
      sdsp_req_beat_type rq;
      if (n_bytes == 0) begin
         send_beat(rand_req(REQ_PUSH_LEVEL));
      end else begin
         for (int k = 0; k < n_bytes; k++) begin
            rq = rand_req(REQ_PUSH_DATA);
            rq.seg_end = (k == n_bytes - 1);
            send_beat(rq);
         end
      end
   endtask

   // Runs a build past the byte limit, then clears the stuck build.
   task automatic send_overlong();
      sdsp_req_beat_type rq;
      int                n_bytes;
      n_bytes = SEGMENT_BYTES + $urandom_range(1, 3);
      for (int k = 0; k < n_bytes; k++) begin
         rq = rand_req(REQ_PUSH_DATA);
         if (k < SEGMENT_BYTES) rq.seg_end = 1'b0;
         send_beat(rq);
      end
      if ($urandom_range(0, 1) == 0) send_beat(rand_req(REQ_PUSH_LEVEL));
      else send_beat(rand_req(REQ_ABORT));
   endtask

   task automatic play_random_step(input bit vary_idling);
      int pick;
      int seg_pick;
      if (vary_idling && $urandom_range(0, 39) == 0) begin
         sender_idles   = 1'($urandom_range(0, 1));
         receiver_idles = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         seg_pick = $urandom_range(0, 99);
         if (seg_pick < 15) send_segment(0);
         else if (seg_pick < 80) send_segment($urandom_range(1, 6));
         else if (seg_pick < 95) send_segment($urandom_range(7, SEGMENT_BYTES - 1));
         else send_segment(SEGMENT_BYTES);
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 6)) send_beat(rand_req(REQ_TICK));
      end else if (pick < 85) begin
         send_beat(rand_req(REQ_XFER_ERROR));
      end else if (pick < 87) begin
         send_beat(rand_req(REQ_ABORT));
      end else if (pick < 95) begin
         send_beat(rand_req(3'($urandom_range(0, 7))));
      end else begin
         send_overlong();
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin : result_side
      int                stall_left;
      sdsp_rsp_beat_type want;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (awaited_link_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result beat %h arrived with none expected", $time, rsp_data);
            end else begin
               want = awaited_link_beats.pop_front();
               results_seen++;
               compare_field("status", 10'(want.status), 10'(rsp_data.status));
               compare_field("byte_valid", 10'(want.byte_valid), 10'(rsp_data.byte_valid));
               compare_field("byte_out", 10'(want.byte_out), 10'(rsp_data.byte_out));
               compare_field("cs_out", 10'(want.cs_out), 10'(rsp_data.cs_out));
               compare_field("dc_out", 10'(want.dc_out), 10'(rsp_data.dc_out));
               compare_field("queued", 10'(want.queued), 10'(rsp_data.queued));
               compare_field("busy_res", 10'(want.busy_res), 10'(rsp_data.busy_res));
               if (want.byte_valid) bytes_played++;
               if (want.status == STATUS_RING_FULL) full_rejects++;
               if (want.status == STATUS_TOO_LONG) long_rejects++;
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (receiver_idles && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 14);
         end
      end
   end

   initial begin : stimulus_side
      int refills;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      tail_slot     = 0;
      head_slot     = 0;
      live_segments = 0;
      build_fill    = 0;
      play_pos      = 0;
      cs_pin        = 1'b1;
      dc_pin        = 1'b1;

      // Empty ring, spare codes, a two-byte segment, level-only segments,
      // a level push over a partial build, transfer error and abort.
      directed_rows.push_back({mk_req(REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b1, 1'b1, 0)});
      directed_rows.push_back({mk_req(REQ_XFER_ERROR, 1'b1, 1'b1, 8'hFF, 1'b1), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b1, 1'b1, 0)});
      directed_rows.push_back({mk_req(REQ_SPARE_7, 1'b1, 1'b1, 8'hFF, 1'b1), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b1, 1'b1, 0)});
      directed_rows.push_back({mk_req(REQ_SPARE_5, 1'b0, 1'b0, 8'h00, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b1, 1'b1, 0)});
      directed_rows.push_back({mk_req(REQ_PUSH_DATA, 1'b1, 1'b1, 8'h00, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b1, 1'b1, 0)});
      directed_rows.push_back({mk_req(REQ_PUSH_DATA, 1'b0, 1'b0, 8'hFF, 1'b1), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b1, 1'b1, 1)});
      directed_rows.push_back({mk_req(REQ_TICK, 1'b1, 1'b1, 8'h5A, 1'b1), 1'b1,
                               mk_rsp(STATUS_OK, 1'b1, 8'h00, 1'b0, 1'b0, 1)});
      directed_rows.push_back({mk_req(REQ_TICK, 1'b0, 1'b1, 8'hA5, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b1, 8'hFF, 1'b0, 1'b0, 0)});
      directed_rows.push_back({mk_req(REQ_PUSH_LEVEL, 1'b0, 1'b1, 8'h00, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b0, 1'b0, 1)});
      directed_rows.push_back({mk_req(REQ_TICK, 1'b1, 1'b0, 8'h00, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b0, 1'b1, 0)});
      directed_rows.push_back({mk_req(REQ_PUSH_DATA, 1'b0, 1'b0, 8'hA5, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b0, 1'b1, 0)});
      directed_rows.push_back({mk_req(REQ_PUSH_LEVEL, 1'b1, 1'b0, 8'h00, 1'b1), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b0, 1'b1, 1)});
      directed_rows.push_back({mk_req(REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b1, 1'b0, 0)});
      directed_rows.push_back({mk_req(REQ_PUSH_DATA, 1'b1, 1'b0, 8'h3C, 1'b0), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_PUSH_DATA, 1'b0, 1'b1, 8'hC3, 1'b1), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_PUSH_LEVEL, 1'b1, 1'b1, 8'h00, 1'b0), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_XFER_ERROR, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_PUSH_DATA, 1'b1, 1'b1, 8'h81, 1'b0), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_PUSH_DATA, 1'b0, 1'b0, 8'h7E, 1'b1), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_PUSH_DATA, 1'b1, 1'b1, 8'h11, 1'b0), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_TICK, 1'b1, 1'b1, 8'h00, 1'b0), 1'b0, NO_RSP});
      directed_rows.push_back({mk_req(REQ_ABORT, 1'b0, 1'b1, 8'h00, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b1, 1'b0, 0)});
      directed_rows.push_back({mk_req(REQ_TICK, 1'b0, 1'b0, 8'h00, 1'b0), 1'b1,
                               mk_rsp(STATUS_OK, 1'b0, 8'h00, 1'b1, 1'b0, 0)});

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

      while (beats_sent < 650) play_random_step(1'b1);

      // Fill the ring to the brim, knock on it while full, then play it out
      // with a few new segments slipped in so the write side wraps around.
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      send_beat(rand_req(REQ_ABORT));
      while (live_segments < RING_SEGMENTS) send_segment(($urandom_range(0, 4) == 0) ? 1 : 0);
      repeat (6) send_beat(rand_req(($urandom_range(0, 1) == 0) ? REQ_PUSH_DATA
                                                                 : REQ_PUSH_LEVEL));
      hold_until_drained();
      refills = 0;
      while (live_segments != 0) begin
         if (refills < 40 && $urandom_range(0, 9) == 0) begin
            send_segment($urandom_range(0, 3));
            refills++;
         end else if ($urandom_range(0, 49) == 0) begin
            send_beat(rand_req(REQ_XFER_ERROR));
         end else begin
            send_beat(rand_req(REQ_TICK));
         end
      end

      while (beats_sent < 1520) play_random_step(1'b1);

      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      while (beats_sent < 1760) play_random_step(1'b0);

      hold_until_drained();
      repeat (8) @(posedge clock);

      $display("Sent %0d request beats (directed rows, random segments, a full and wrapped ring)",
               beats_sent);
      $display("and checked %0d result beats: %0d bytes played, %0d ring-full, %0d too-long.",
               results_seen, bytes_played, full_rejects, long_rejects);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
